FILE: src/sync_length_crc_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver_macros
// assertion macros used by the frame receiver top module
// ----------------------------------------------------------------------------
`ifndef SYNC_LENGTH_CRC_FRAME_RECEIVER_MACROS_SVH
`define SYNC_LENGTH_CRC_FRAME_RECEIVER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SLCFR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("frame receiver check failed");

// next-cycle implication
`define SLCFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("frame receiver check failed");

`else

`define SLCFR_ASSERT_SAME(label, clk, rstn, ante, cons)
`define SLCFR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: src/slcfr_pkg.sv
// ----------------------------------------------------------------------------
// slcfr_pkg
// types, codes and the crc step shared by the frame receiver modules
// ----------------------------------------------------------------------------
package slcfr_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;

    // register indexes
    localparam logic [2:0] REG_SYNC_FIRST  = 3'd0;
    localparam logic [2:0] REG_SYNC_SECOND = 3'd1;
    localparam logic [2:0] REG_FRAME_TYPE  = 3'd2;
    localparam logic [2:0] REG_MAX_LENGTH  = 3'd3;
    localparam logic [2:0] REG_CRC_INIT    = 3'd4;

    // receive phases
    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_CRC_LO  = 2'd2;
    localparam logic [1:0] PH_CRC_HI  = 2'd3;

    // back-end operations
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_CRC_LO = 2'd2;
    localparam logic [1:0] OP_END    = 2'd3;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  frame_type;
        logic [7:0]  max_length;
        logic [15:0] crc_init;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  data;
        logic [15:0] seed;
        logic [7:0]  count;
    } cmd_t;

    typedef struct packed {
        logic                full;
        logic                empty;
        logic [QUEUE_CW-1:0] level;
    } q_stat_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: src/sync_length_crc_frame_receiver.sv
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver
// sync/length/type header hunt with crc-16-ccitt check of each frame
//
//   channel   dir   handshake              payload
//   s_        in    s_valid / s_ready      s_in_byte
//   m_        out   m_valid / m_ready      m_out_byte, m_is_end, m_crc_good,
//                                          m_payload_count
//   cfg_      in    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one input beat per cycle while the queue has room; a result reaches m_ once its beat
// has passed front classify and queue write, then back crc step into the result register
// the four-entry queue lets the front take beats while the result side stalls
// synchronous active-low reset; no clearing pass, ready right after reset
// cfg_ready is always high; registers take the write at once
// ----------------------------------------------------------------------------
`include "sync_length_crc_frame_receiver_macros.svh"

module sync_length_crc_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_is_end,
    output logic        m_crc_good,
    output logic [7:0]  m_payload_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    slcfr_pkg::cfg_t    cfg_reg, cfg_next;
    slcfr_pkg::cmd_t    push_cmd;
    slcfr_pkg::cmd_t    head;
    slcfr_pkg::q_stat_t q_stat;
    logic               push;
    logic               pop;
    logic               status_clear;

    assign cfg_ready    = 1'b1;
    assign status_clear = !m_crc_good && (m_payload_count == 8'd0);

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                slcfr_pkg::REG_SYNC_FIRST:  cfg_next.sync_first  = cfg_data[7:0];
                slcfr_pkg::REG_SYNC_SECOND: cfg_next.sync_second = cfg_data[7:0];
                slcfr_pkg::REG_FRAME_TYPE:  cfg_next.frame_type  = cfg_data[7:0];
                slcfr_pkg::REG_MAX_LENGTH:  cfg_next.max_length  = cfg_data[7:0];
                slcfr_pkg::REG_CRC_INIT:    cfg_next.crc_init    = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first  <= 8'h00;
            cfg_reg.sync_second <= 8'h00;
            cfg_reg.frame_type  <= 8'h00;
            cfg_reg.max_length  <= 8'hFF;
            cfg_reg.crc_init    <= 16'hFFFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    slcfr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_in_byte (s_in_byte),
        .q_full    (q_stat.full),
        .push      (push),
        .cmd       (push_cmd)
    );

    slcfr_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    slcfr_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .head            (head),
        .head_valid      (!q_stat.empty),
        .pop             (pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_end        (m_is_end),
        .m_crc_good      (m_crc_good),
        .m_payload_count (m_payload_count)
    );

    `SLCFR_ASSERT_SAME(a_payload_no_status, aclk, aresetn, m_valid && !m_is_end, status_clear)
    `SLCFR_ASSERT_SAME(a_end_zero_byte, aclk, aresetn, m_valid && m_is_end, m_out_byte == 8'd0)
    `SLCFR_ASSERT_SAME(a_full_stalls_input, aclk, aresetn, q_stat.full, !s_ready && !push)
    `SLCFR_ASSERT_NEXT(a_full_not_drained, aclk, aresetn, q_stat.full, !q_stat.empty)

endmodule

FILE: src/slcfr_front.sv
// ----------------------------------------------------------------------------
// slcfr_front
// header hunt and frame phase tracking, issues one command per useful beat
// ----------------------------------------------------------------------------
module slcfr_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  slcfr_pkg::cfg_t   cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_in_byte,
    input  logic              q_full,
    output logic              push,
    output slcfr_pkg::cmd_t   cmd
);

    logic [23:0] window_reg, window_next;
    logic [1:0]  fill_reg, fill_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  left_reg, left_next;
    logic [7:0]  total_reg, total_next;

    logic        accept;
    logic        hdr_ok;
    logic [7:0]  len;
    logic [7:0]  len_m1;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign len     = window_reg[7:0];
    assign len_m1  = len - 8'd1;
    assign hdr_ok  = (fill_reg == 2'd3) && (window_reg[23:16] == cfg.sync_first) &&
                     (window_reg[15:8] == cfg.sync_second) && (s_in_byte == cfg.frame_type) &&
                     (len != 8'd0) && (len <= cfg.max_length);

    always_comb begin
        window_next = window_reg;
        fill_next   = fill_reg;
        phase_next  = phase_reg;
        left_next   = left_reg;
        total_next  = total_reg;
        push        = 1'b0;
        cmd.op      = slcfr_pkg::OP_DATA;
        cmd.data    = s_in_byte;
        cmd.seed    = cfg.crc_init;
        cmd.count   = total_reg;
        if (accept) begin
            unique case (phase_reg)
                slcfr_pkg::PH_HUNT: begin
                    if (hdr_ok) begin
                        push        = 1'b1;
                        cmd.op      = slcfr_pkg::OP_START;
                        left_next   = len_m1;
                        total_next  = len_m1;
                        phase_next  = (len_m1 == 8'd0) ? slcfr_pkg::PH_CRC_LO
                                                       : slcfr_pkg::PH_PAYLOAD;
                        window_next = '0;
                        fill_next   = '0;
                    end else begin
                        window_next = {window_reg[15:0], s_in_byte};
                        if (fill_reg != 2'd3) begin
                            fill_next = fill_reg + 2'd1;
                        end
                    end
                end
                slcfr_pkg::PH_PAYLOAD: begin
                    push      = 1'b1;
                    cmd.op    = slcfr_pkg::OP_DATA;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1) begin
                        phase_next = slcfr_pkg::PH_CRC_LO;
                    end
                end
                slcfr_pkg::PH_CRC_LO: begin
                    push       = 1'b1;
                    cmd.op     = slcfr_pkg::OP_CRC_LO;
                    phase_next = slcfr_pkg::PH_CRC_HI;
                end
                slcfr_pkg::PH_CRC_HI: begin
                    push        = 1'b1;
                    cmd.op      = slcfr_pkg::OP_END;
                    phase_next  = slcfr_pkg::PH_HUNT;
                    window_next = '0;
                    fill_next   = '0;
                    left_next   = '0;
                end
                default: begin
                    phase_next = slcfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            fill_reg   <= '0;
            phase_reg  <= slcfr_pkg::PH_HUNT;
            left_reg   <= '0;
            total_reg  <= '0;
        end else begin
            window_reg <= window_next;
            fill_reg   <= fill_next;
            phase_reg  <= phase_next;
            left_reg   <= left_next;
            total_reg  <= total_next;
        end
    end

endmodule

FILE: src/slcfr_queue.sv
// ----------------------------------------------------------------------------
// slcfr_queue
// short command queue between the front and back ends
// ----------------------------------------------------------------------------
module slcfr_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  slcfr_pkg::cmd_t     push_cmd,
    input  logic                pop,
    output slcfr_pkg::cmd_t     head,
    output slcfr_pkg::q_stat_t  stat
);

    slcfr_pkg::cmd_t                   slot_reg [slcfr_pkg::QUEUE_DEPTH];
    logic [slcfr_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [slcfr_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [slcfr_pkg::QUEUE_CW-1:0]    level_reg, level_next;
    logic                              do_push;
    logic                              do_pop;

    assign stat.full  = (level_reg == slcfr_pkg::QUEUE_CW'(slcfr_pkg::QUEUE_DEPTH));
    assign stat.empty = (level_reg == '0);
    assign stat.level = level_reg;
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (do_push && !do_pop) begin
            level_next = level_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

endmodule

FILE: src/slcfr_back.sv
// ----------------------------------------------------------------------------
// slcfr_back
// crc engine and result register, carries out queued commands
// ----------------------------------------------------------------------------
module slcfr_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  slcfr_pkg::cmd_t     head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_is_end,
    output logic                m_crc_good,
    output logic [7:0]          m_payload_count
);

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  low_reg, low_next;
    logic        valid_reg, valid_next;
    logic [7:0]  byte_reg, byte_next;
    logic        end_reg, end_next;
    logic        good_reg, good_next;
    logic [7:0]  count_reg, count_next;

    logic        emits;
    logic        out_free;

    assign emits    = (head.op == slcfr_pkg::OP_DATA) || (head.op == slcfr_pkg::OP_END);
    assign out_free = !valid_reg || m_ready;
    assign pop      = head_valid && (!emits || out_free);

    always_comb begin
        crc_next   = crc_reg;
        low_next   = low_reg;
        valid_next = valid_reg && !m_ready;
        byte_next  = byte_reg;
        end_next   = end_reg;
        good_next  = good_reg;
        count_next = count_reg;
        if (pop) begin
            unique case (head.op)
                slcfr_pkg::OP_START: begin
                    crc_next = slcfr_pkg::crc_byte(head.seed, head.data);
                end
                slcfr_pkg::OP_DATA: begin
                    crc_next   = slcfr_pkg::crc_byte(crc_reg, head.data);
                    valid_next = 1'b1;
                    byte_next  = head.data;
                    end_next   = 1'b0;
                    good_next  = 1'b0;
                    count_next = '0;
                end
                slcfr_pkg::OP_CRC_LO: begin
                    low_next = head.data;
                end
                slcfr_pkg::OP_END: begin
                    valid_next = 1'b1;
                    byte_next  = '0;
                    end_next   = 1'b1;
                    good_next  = ({head.data, low_reg} == crc_reg);
                    count_next = head.count;
                end
                default: begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg   <= 16'hFFFF;
            low_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            crc_reg   <= crc_next;
            low_reg   <= low_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg  <= byte_next;
        end_reg   <= end_next;
        good_reg  <= good_next;
        count_reg <= count_next;
    end

    assign m_valid         = valid_reg;
    assign m_out_byte      = byte_reg;
    assign m_is_end        = end_reg;
    assign m_crc_good      = good_reg;
    assign m_payload_count = count_reg;

endmodule
